@@ rtl/core/esc_pkg.sv @@
package esc_pkg;

    // Calendar constants
    localparam logic [11:0] EPOCH_YEAR      = 12'd1970;
    localparam logic [11:0] NONLEAP_CENTURY = 12'd2100;   // only century year in range that skips
    localparam logic [16:0] SECS_PER_DAY    = 17'd86400;
    localparam logic [16:0] SECS_PER_HOUR   = 17'd3600;
    localparam logic [16:0] SECS_PER_MIN    = 17'd60;
    localparam logic [16:0] DAYS_PER_WEEK   = 17'd7;
    localparam logic [15:0] EPOCH_WEEKDAY   = 16'd4;      // 1970-01-01 was a Thursday
    localparam logic [8:0]  DAYS_PER_YEAR   = 9'd365;
    localparam logic [8:0]  DAYS_PER_LEAP   = 9'd366;
    localparam logic signed [16:0] OFFSET_RESET = 17'sd28800;

    // Reciprocals, exact over each dividend's range
    //   day : (x >> 7) / 675, 25-bit operand, >> 35
    //   week: x / 7,          16-bit operand, >> 19
    //   hour: (x >> 4) / 225, 13-bit operand, >> 21
    //   min : (x >> 2) / 15,  10-bit operand, >> 14
    localparam logic [50:0] RECIP_DAY  = 51'd50903317;
    localparam logic [50:0] RECIP_WEEK = 51'd74899;
    localparam logic [50:0] RECIP_HOUR = 51'd9321;
    localparam logic [50:0] RECIP_MIN  = 51'd1093;

    typedef struct packed {
        logic [31:0] counter_seconds;
    } in_item_t;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  weekday;
    } out_item_t;

    typedef struct packed {
        logic signed [16:0] zone_offset_seconds;
    } cfg_item_t;

    // Microcode
    typedef enum logic [2:0] {
        OP_DIV,
        OP_SAVE_DAYS,
        OP_SAVE_WDAY,
        OP_SAVE_HOUR,
        OP_SAVE_MIN,
        OP_YEAR,
        OP_MONTH,
        OP_EMIT
    } op_t;

    typedef enum logic [1:0] {
        DIV_DAY,
        DIV_WEEK,
        DIV_HOUR,
        DIV_MIN
    } div_sel_t;

    typedef enum logic [1:0] {
        JMP_NONE,       // fall through
        JMP_SUB_MORE,   // a year or month was taken off
        JMP_OUT_BUSY    // output register still occupied
    } jmp_t;

    typedef logic [3:0] upc_t;

    typedef struct packed {
        op_t      op;
        div_sel_t div_sel;
        jmp_t     jmp;
        upc_t     target;
    } ctrl_word_t;

    function automatic ctrl_word_t microcode(input upc_t pc);
        ctrl_word_t w;
        w = '{op: OP_EMIT, div_sel: DIV_DAY, jmp: JMP_NONE, target: 4'd0};
        unique case (pc)
            4'd0:  w = '{OP_DIV,       DIV_DAY,  JMP_NONE,     4'd0};
            4'd1:  w = '{OP_SAVE_DAYS, DIV_DAY,  JMP_NONE,     4'd0};
            4'd2:  w = '{OP_DIV,       DIV_WEEK, JMP_NONE,     4'd0};
            4'd3:  w = '{OP_SAVE_WDAY, DIV_WEEK, JMP_NONE,     4'd0};
            4'd4:  w = '{OP_DIV,       DIV_HOUR, JMP_NONE,     4'd0};
            4'd5:  w = '{OP_SAVE_HOUR, DIV_HOUR, JMP_NONE,     4'd0};
            4'd6:  w = '{OP_DIV,       DIV_MIN,  JMP_NONE,     4'd0};
            4'd7:  w = '{OP_SAVE_MIN,  DIV_MIN,  JMP_NONE,     4'd0};
            4'd8:  w = '{OP_YEAR,      DIV_DAY,  JMP_SUB_MORE, 4'd8};
            4'd9:  w = '{OP_MONTH,     DIV_DAY,  JMP_SUB_MORE, 4'd9};
            4'd10: w = '{OP_EMIT,      DIV_DAY,  JMP_OUT_BUSY, 4'd10};
            default: w = '{OP_EMIT,    DIV_DAY,  JMP_NONE,     4'd0};
        endcase
        return w;
    endfunction

    function automatic logic [16:0] div_value(input div_sel_t sel);
        logic [16:0] v;
        unique case (sel)
            DIV_DAY:  v = SECS_PER_DAY;
            DIV_WEEK: v = DAYS_PER_WEEK;
            DIV_HOUR: v = SECS_PER_HOUR;
            DIV_MIN:  v = SECS_PER_MIN;
            default:  v = SECS_PER_DAY;
        endcase
        return v;
    endfunction

    // Quotient of x by the selected constant
    function automatic logic [15:0] recip_quotient(input div_sel_t sel, input logic [31:0] x);
        logic [50:0] p;
        logic [15:0] q;
        unique case (sel)
            DIV_DAY:
            begin
                p = {26'd0, x[31:7]} * RECIP_DAY;
                q = p[50:35];
            end
            DIV_WEEK:
            begin
                p = {35'd0, x[15:0]} * RECIP_WEEK;
                q = p[34:19];
            end
            DIV_HOUR:
            begin
                p = {38'd0, x[16:4]} * RECIP_HOUR;
                q = p[36:21];
            end
            DIV_MIN:
            begin
                p = {41'd0, x[11:2]} * RECIP_MIN;
                q = p[29:14];
            end
            default:
            begin
                p = '0;
                q = '0;
            end
        endcase
        return q;
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
            4'd2:                                        d = leap ? 5'd29 : 5'd28;
            default:                                     d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

@@ rtl/core/esc_stream_if.sv @@
interface esc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/epoch_seconds_to_calendar.sv @@
// Converts an RTC seconds count (since 1970-01-01 00:00:00) into local
// calendar date, time of day and weekday.
//
// Channels (valid/ready, item moves when both are high):
//   sample : one 32-bit counter_seconds per item.
//   result : year, month, day_of_month, hour, minute, second, weekday.
//   cfg    : write of zone_offset_seconds (signed 17 bits), always ready.
//            Write only while no conversion is in flight.
// Conversion time grows with each year past 1970 and each month past
// January and is longest for December 2105. The year loop of the
// microcode sequencer dominates; each division by a fixed constant takes two
// steps, a reciprocal multiply for the quotient and a multiply-subtract for
// the remainder. One item is converted at a time; the next item is taken the
// cycle after the previous result lands in the output register.
// Reset: sequencer idle, output empty, offset back to +8 hours (28800 s).
// Stall: a result waits in the output register; the sequencer holds at its
// last step until that register frees up.
module epoch_seconds_to_calendar (
    input  logic         clk,
    input  logic         rst_n,
    esc_stream_if.sink   sample,
    esc_stream_if.source result,
    esc_stream_if.sink   cfg
);
    import esc_pkg::*;

    // Control state
    logic       busy_reg,      busy_next;
    upc_t       pc_reg,        pc_next;
    logic       out_valid_reg, out_valid_next;
    logic signed [16:0] offset_reg, offset_next;

    // Datapath
    logic [31:0] rem_reg,  rem_next;    // dividend / remainder
    logic [15:0] quo_reg,  quo_next;
    logic [15:0] days_reg, days_next;
    logic [16:0] hms_reg,  hms_next;
    logic [11:0] year_reg, year_next;
    logic [3:0]  month_reg, month_next;
    out_item_t   work_reg, work_next;   // hour/minute/second/weekday collect here
    out_item_t   out_reg,  out_next;

    ctrl_word_t  cw;
    logic        take_in;
    logic        out_free;
    logic [15:0] div_quo;
    logic [31:0] div_rem;
    logic        leap;
    logic [8:0]  year_len;
    logic        year_ge;
    logic [4:0]  mon_len;
    logic        mon_ge;
    logic        jump;
    logic [31:0] t_sum;

    assign cw       = microcode(pc_reg);
    assign take_in  = sample.valid && sample.ready;
    assign out_free = !out_valid_reg || result.ready;

    assign sample.ready   = !busy_reg;
    assign cfg.ready      = 1'b1;
    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

    // Local seconds, wraps mod 2^32
    assign t_sum = sample.payload.counter_seconds
                 + {{15{offset_reg[16]}}, offset_reg};

    // Constant division: quotient on the divide step, remainder on the save step
    assign div_quo = recip_quotient(cw.div_sel, rem_reg);
    assign div_rem = rem_reg - {16'd0, quo_reg} * {15'd0, div_value(cw.div_sel)};

    // Leap test holds for 1970..2106: 2000 is leap, 2100 is not
    assign leap     = (year_reg[1:0] == 2'd0) && (year_reg != NONLEAP_CENTURY);
    assign year_len = leap ? DAYS_PER_LEAP : DAYS_PER_YEAR;
    assign year_ge  = days_reg >= {7'd0, year_len};
    assign mon_len  = month_days(month_reg, leap);
    assign mon_ge   = (month_reg != 4'd12) && (days_reg >= {11'd0, mon_len});

    always_comb
    begin
        unique case (cw.jmp)
            JMP_NONE:     jump = 1'b0;
            JMP_SUB_MORE: jump = (cw.op == OP_YEAR) ? year_ge : mon_ge;
            JMP_OUT_BUSY: jump = !out_free;
            default:      jump = 1'b0;
        endcase
    end

    always_comb
    begin
        busy_next      = busy_reg;
        pc_next        = pc_reg;
        out_valid_next = out_valid_reg && !result.ready;
        offset_next    = offset_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        days_next      = days_reg;
        hms_next       = hms_reg;
        year_next      = year_reg;
        month_next     = month_reg;
        work_next      = work_reg;
        out_next       = out_reg;

        if (cfg.valid)
        begin
            offset_next = cfg.payload.zone_offset_seconds;
        end

        if (take_in)
        begin
            busy_next = 1'b1;
            pc_next   = '0;
            rem_next  = t_sum;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            pc_next = jump ? cw.target : pc_reg + 4'd1;
            unique case (cw.op)
                OP_DIV:
                begin
                    quo_next = div_quo;
                end
                OP_SAVE_DAYS:
                begin
                    days_next = quo_reg;
                    hms_next  = div_rem[16:0];
                    rem_next  = {16'd0, quo_reg + EPOCH_WEEKDAY};
                end
                OP_SAVE_WDAY:
                begin
                    work_next.weekday = div_rem[2:0];
                    rem_next          = {15'd0, hms_reg};
                end
                OP_SAVE_HOUR:
                begin
                    work_next.hour = quo_reg[4:0];
                    rem_next       = div_rem;
                end
                OP_SAVE_MIN:
                begin
                    work_next.minute = quo_reg[5:0];
                    work_next.second = div_rem[5:0];
                    year_next        = EPOCH_YEAR;
                    month_next       = 4'd1;
                end
                OP_YEAR:
                begin
                    if (year_ge)
                    begin
                        days_next = days_reg - {7'd0, year_len};
                        year_next = year_reg + 12'd1;
                    end
                end
                OP_MONTH:
                begin
                    if (mon_ge)
                    begin
                        days_next  = days_reg - {11'd0, mon_len};
                        month_next = month_reg + 4'd1;
                    end
                end
                OP_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_next        = 1'b1;
                        out_next              = work_reg;
                        out_next.year         = year_reg;
                        out_next.month        = month_reg;
                        out_next.day_of_month = days_reg[4:0] + 5'd1;
                        busy_next             = 1'b0;
                        pc_next               = '0;
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                    pc_next   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
            offset_reg    <= OFFSET_RESET;
        end
        else
        begin
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
            offset_reg    <= offset_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        days_reg  <= days_next;
        hms_reg   <= hms_next;
        year_reg  <= year_next;
        month_reg <= month_next;
        work_reg  <= work_next;
        out_reg   <= out_next;
    end

endmodule

@@ tb/sv/calendar_checker.sv @@
`timescale 1ns / 100ps

module calendar_checker
    import esc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      sample_valid,
    input  logic      sample_ready,
    input  in_item_t  sample_item,
    input  logic      result_valid,
    input  logic      result_ready,
    input  out_item_t result_item,
    input  logic      cfg_valid,
    input  logic      cfg_ready,
    input  cfg_item_t cfg_item,
    output int        mismatches,
    output int        awaited,
    output int        converted
);

    localparam int unsigned MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam int unsigned MONTH_START [12] =
        '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [31:0]        counter;
        logic signed [16:0] zone;
        out_item_t          date;
    } pending_date_t;

    logic signed [16:0] zone_offset;
    pending_date_t      date_queue [$];

    function automatic bit is_leap_year(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    // Local calendar date and time of a counter value under a zone offset.
    function automatic out_item_t to_calendar(input logic [31:0] count,
                                              input logic signed [16:0] zone);
        logic [31:0] local_secs;
        int unsigned days;
        int unsigned sod;
        int unsigned y;
        int unsigned m;
        int unsigned mlen;
        int unsigned prior;
        int unsigned total;
        out_item_t   r;
        local_secs = count + {{15{zone[16]}}, zone};   // wraps mod 2^32
        days = local_secs / 32'd86400;
        sod  = local_secs % 32'd86400;
        y = 1970;
        while (days >= (is_leap_year(y) ? 366 : 365))
        begin
            days -= is_leap_year(y) ? 366 : 365;
            y++;
        end
        m = 1;
        while (m < 12)
        begin
            mlen = MONTH_LEN[m - 1];
            if (m == 2 && is_leap_year(y))
                mlen = 29;
            if (days < mlen)
                break;
            days -= mlen;
            m++;
        end
        prior = y - 1;
        total = prior * 365 + prior / 4 - prior / 100 + prior / 400
              + MONTH_START[m - 1] + days + 1;
        if (is_leap_year(y) && m > 2)
            total++;
        r.year         = 12'(y);
        r.month        = 4'(m);
        r.day_of_month = 5'(days + 1);
        r.hour         = 5'(sod / 3600);
        r.minute       = 6'((sod % 3600) / 60);
        r.second       = 6'(sod % 60);
        r.weekday      = 3'(total % 7);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pending_date_t e;
        if (!rst_n)
        begin
            zone_offset = OFFSET_RESET;
            date_queue.delete();
            mismatches  = 0;
            awaited     = 0;
            converted   = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                zone_offset = cfg_item.zone_offset_seconds;

            // pop before push: a result never belongs to an item taken this edge
            if (result_valid && result_ready)
            begin
                converted++;
                if (date_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%t unexpected result %0d-%0d-%0d %0d:%0d:%0d wd %0d",
                                 $realtime,
                                 result_item.year, result_item.month, result_item.day_of_month,
                                 result_item.hour, result_item.minute, result_item.second,
                                 result_item.weekday);
                end
                else
                begin
                    e = date_queue.pop_front();
                    if (result_item.year !== e.date.year
                        || result_item.month !== e.date.month
                        || result_item.day_of_month !== e.date.day_of_month
                        || result_item.hour !== e.date.hour
                        || result_item.minute !== e.date.minute
                        || result_item.second !== e.date.second
                        || result_item.weekday !== e.date.weekday)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                        begin
                            $display("%t counter %h zone %0d:", $realtime, e.counter, e.zone);
                            $display("    exp %0d-%0d-%0d %0d:%0d:%0d wd %0d",
                                     e.date.year, e.date.month, e.date.day_of_month,
                                     e.date.hour, e.date.minute, e.date.second,
                                     e.date.weekday);
                            $display("    got %0d-%0d-%0d %0d:%0d:%0d wd %0d",
                                     result_item.year, result_item.month,
                                     result_item.day_of_month, result_item.hour,
                                     result_item.minute, result_item.second,
                                     result_item.weekday);
                        end
                    end
                end
            end

            if (sample_valid && sample_ready)
            begin
                e.counter = sample_item.counter_seconds;
                e.zone    = zone_offset;
                e.date    = to_calendar(sample_item.counter_seconds, zone_offset);
                date_queue.push_back(e);
            end

            awaited = date_queue.size();
        end
    end

endmodule

@@ tb/sv/epoch_seconds_to_calendar_tb.sv @@
`timescale 1ns / 100ps

module epoch_seconds_to_calendar_tb;
    import esc_pkg::*;

    // Cycles without any item moving before the run is declared hung.
    // Slowest conversion is the one for December 2105, and receiver stalls add to it.
    localparam int HANG_LIMIT   = 4000;
    localparam int TAIL_CYCLES  = 250;
    localparam int PHASE_ITEMS  = 180;
    localparam int IDLE_PERCENT = 17;

    logic clk = 1'b0;
    logic rst_n;

    esc_stream_if #(.payload_t(in_item_t))  sample_ch ();
    esc_stream_if #(.payload_t(out_item_t)) result_ch ();
    esc_stream_if #(.payload_t(cfg_item_t)) cfg_ch ();

    int mismatches;
    int awaited;
    int converted;
    int zone_writes;
    int idle_cycles;
    bit calm;   // no idling on either side while set

    epoch_seconds_to_calendar DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    calendar_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_ch.valid),
        .sample_ready (sample_ch.ready),
        .sample_item  (sample_ch.payload),
        .result_valid (result_ch.valid),
        .result_ready (result_ch.ready),
        .result_item  (result_ch.payload),
        .cfg_valid    (cfg_ch.valid),
        .cfg_ready    (cfg_ch.ready),
        .cfg_item     (cfg_ch.payload),
        .mismatches   (mismatches),
        .awaited      (awaited),
        .converted    (converted)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Result side: drops ready about 17% of cycles unless in a calm stretch.
    always @(negedge clk)
        result_ch.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);

    // Hang detector: counts cycles with no item moving on any channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= HANG_LIMIT)
            begin
                $display("%t no item moved for %0d cycles, %0d results outstanding",
                         $realtime, HANG_LIMIT, awaited);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Offers one counter item; entered and left at a falling edge, valid left high
    // so back-to-back items need no gap.
    task automatic feed_counter(input logic [31:0] count);
        while (!calm && $urandom_range(99) < IDLE_PERCENT)
        begin
            sample_ch.valid <= 1'b0;
            @(negedge clk);
        end
        sample_ch.valid                   <= 1'b1;
        sample_ch.payload.counter_seconds <= count;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Holds the sample side off until every conversion in flight has come out.
    task automatic wait_all_converted();
        sample_ch.valid <= 1'b0;
        @(negedge clk);
        while (awaited != 0)
            @(negedge clk);
    endtask

    // Offset write, only with the converter idle.
    task automatic load_zone(input logic signed [16:0] zone);
        wait_all_converted();
        cfg_ch.valid                       <= 1'b1;
        cfg_ch.payload.zone_offset_seconds <= zone;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        zone_writes++;
    endtask

    // Random counter: mostly uniform, plus short conversions, wrap-prone values
    // near the top, day edges and the non-leap century year 2100.
    function automatic logic [31:0] pick_counter();
        int unsigned pick;
        logic [31:0] c;
        pick = $urandom_range(99);
        if (pick < 55)
            c = $urandom;
        else if (pick < 70)
            c = $urandom_range(32'h00FF_FFFF, 0);
        else if (pick < 80)
            c = {16'hFFFF, 16'($urandom)};
        else if (pick < 92)
            c = 32'($urandom_range(49709, 0)) * 32'd86400 - 32'($urandom_range(1, 0));
        else
            c = 32'd4102444800 + 32'($urandom_range(86400 * 400, 0));
        return c;
    endfunction

    function automatic logic signed [16:0] pick_zone(input int unsigned kind);
        logic signed [16:0] z;
        case (kind)
            0:       z = OFFSET_RESET;
            1:       z = 17'($signed($urandom_range(100800, 0)) - 50400);
            2:       z = 17'($urandom);   // any 17-bit pattern, beyond stated range too
            3:       z = 17'($signed($urandom_range(100800, 0)) - 50400);
            default: z = '0;
        endcase
        return z;
    endfunction

    initial
    begin
        rst_n             = 1'b0;
        calm              = 1'b0;
        zone_writes       = 0;
        idle_cycles       = 0;
        sample_ch.valid   = 1'b0;
        sample_ch.payload = '0;
        result_ch.ready   = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.payload    = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset offset of +8 hours first.
        feed_counter(32'd0);             // 1970-01-01 08:00, Thursday
        feed_counter(32'hFFFF_FFFF);     // sum wraps into early 1970
        feed_counter(32'd951782400);     // 2000-02-29, leap century
        feed_counter(32'd4107542399);    // 2100-02-28 end of day UTC
        feed_counter(32'd4107542400);    // 2100-03-01, century without leap day

        load_zone(17'sd0);
        feed_counter(32'd0);             // the epoch itself
        feed_counter(32'hFFFF_FFFF);     // top of range, 2106
        feed_counter(32'd31535999);      // last second of 1970
        feed_counter(32'd978220799);     // 2000-12-30 23:59:59, day 365
        feed_counter(32'd86399);         // 23:59:59 of day one
        feed_counter(32'd951782399);     // 2000-02-28 23:59:59

        // Most negative pattern: small counts wrap into 2106.
        load_zone(-17'sd65536);
        feed_counter(32'd0);
        feed_counter(32'd65535);

        // Most positive pattern: a count near the top wraps into 1970, one below it lands on the top of 2106.
        load_zone(17'sd65535);
        feed_counter(32'hFFFF_FF9B);
        feed_counter(32'hFFFF_0000);

        // Stated range ends.
        load_zone(-17'sd50400);
        feed_counter(32'd0);
        feed_counter(32'd50399);
        load_zone(17'sd50400);
        feed_counter(32'hFFFF_0000);
        feed_counter(32'd1700000000);

        // Random phases, each under its own offset.
        for (int phase = 0; phase < 5; phase++)
        begin
            load_zone(pick_zone(phase));
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                calm = (phase == 2) && (i < 120);
                if (i == PHASE_ITEMS / 2)
                    wait_all_converted();
                feed_counter(pick_counter());
            end
            calm = 1'b0;
        end

        wait_all_converted();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("covered %0d conversions under %0d offset writes plus reset value:", converted,
                 zone_writes);
        $display("epoch and top-of-range counts, wraparound both ways, leap and century days");
        if (mismatches == 0 && awaited == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
